// ===== hw/rtl/vcpd_pkg.sv =====
// vcpd_pkg: widths and register indexes for the view cone and plane distance test
// used by view_cone_and_plane_distance_test_core; no dependencies
package vcpd_pkg;

  // coordinate and fixed-point widths
  localparam int COORD_WIDTH = 16;
  localparam int FIX_W       = 16;
  localparam int CFG_W       = (COORD_WIDTH > FIX_W) ? COORD_WIDTH : FIX_W;
  localparam int IDX_W       = 3;

  // derived datapath widths
  localparam int DIFF_W   = COORD_WIDTH + 1;
  localparam int PROD_W   = DIFF_W + COORD_WIDTH;
  localparam int DOT_W    = PROD_W + 2;
  localparam int DMAG_W   = DOT_W - 1;
  localparam int RSQ_W    = 2 * COORD_WIDTH + 1;
  localparam int R2_W     = RSQ_W + 2;
  localparam int NSQ_W    = 2 * COORD_WIDTH - 1;
  localparam int N2_W     = NSQ_W + 2;
  localparam int C2_W     = 2 * FIX_W - 1;
  localparam int RE2_W    = 2 * FIX_W;
  localparam int DRE_W    = RE2_W + N2_W;
  localparam int DOT2_W   = 2 * DMAG_W;
  localparam int RN_W     = R2_W + N2_W;
  localparam int RN_LO_W  = RN_W / 2;
  localparam int RN_HI_W  = RN_W - RN_LO_W;
  localparam int PP_LO_W  = C2_W + RN_LO_W;
  localparam int PP_HI_W  = C2_W + RN_HI_W;
  localparam int FRAC_SH  = 2 * (FIX_W - 1);
  localparam int LHS_W    = DOT2_W + FRAC_SH;
  localparam int RHS_W    = PP_HI_W + RN_LO_W + 1;
  localparam int CMP_W    = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int DIST_W   = (DOT2_W > DRE_W) ? DOT2_W : DRE_W;

  localparam int NSTAGE = 7;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_CAMERA_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_CAMERA_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_CAMERA_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_NORMAL_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_NORMAL_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_NORMAL_Z = 3'd5;
  localparam logic [IDX_W-1:0] REG_COS_HALF = 3'd6;
  localparam logic [IDX_W-1:0] REG_REACH    = 3'd7;

endpackage

// ===== hw/rtl/view_cone_and_plane_distance_test_core.sv =====
// view_cone_and_plane_distance_test_core: seven-stage pipelined cone and distance test
// depends on vcpd_pkg for widths and register indexes
// throughput: one item per cycle; a stage loads when it is empty or the stage after it moves on,
// so bubbles close up and a held result stalls the input only once every stage is full
// reset: rst (synchronous) empties the pipeline and loads the register reset values
module view_cone_and_plane_distance_test_core (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [vcpd_pkg::IDX_W-1:0]               cfg_index,
  input  logic [vcpd_pkg::CFG_W-1:0]               cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [vcpd_pkg::COORD_WIDTH-1:0]  center_x,
  input  logic signed [vcpd_pkg::COORD_WIDTH-1:0]  center_y,
  input  logic signed [vcpd_pkg::COORD_WIDTH-1:0]  center_z,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic                                     outside,
  output logic                                     zero_normal
);
  import vcpd_pkg::*;

  // configuration registers
  logic signed [COORD_WIDTH-1:0] camera_x, camera_y, camera_z;
  logic signed [COORD_WIDTH-1:0] normal_x, normal_y, normal_z;
  logic signed [FIX_W-1:0]       cos_half_angle;
  logic [FIX_W-1:0]              reach;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x       <= '0;
      camera_y       <= '0;
      camera_z       <= '0;
      normal_x       <= '0;
      normal_y       <= '0;
      normal_z       <= COORD_WIDTH'(1);
      cos_half_angle <= '0;
      reach          <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CAMERA_X: camera_x       <= cfg_data[COORD_WIDTH-1:0];
        REG_CAMERA_Y: camera_y       <= cfg_data[COORD_WIDTH-1:0];
        REG_CAMERA_Z: camera_z       <= cfg_data[COORD_WIDTH-1:0];
        REG_NORMAL_X: normal_x       <= cfg_data[COORD_WIDTH-1:0];
        REG_NORMAL_Y: normal_y       <= cfg_data[COORD_WIDTH-1:0];
        REG_NORMAL_Z: normal_z       <= cfg_data[COORD_WIDTH-1:0];
        REG_COS_HALF: cos_half_angle <= cfg_data[FIX_W-1:0];
        REG_REACH:    reach          <= cfg_data[FIX_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits and per-stage load enables
  logic [NSTAGE:1] v;
  logic [NSTAGE:1] ready;

  always_comb begin
    ready[NSTAGE] = !v[NSTAGE] || !out_stall;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      ready[k] = !v[k] || ready[k+1];
    end
  end

  assign in_stall  = !ready[1];
  assign out_valid = v[NSTAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ready[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (ready[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // config flags; the user must keep the config stable while items are in flight, the core does not enforce it
  logic n_zero;
  assign n_zero = (normal_x == '0) && (normal_y == '0) && (normal_z == '0);

  // stage 1: offset from camera
  logic signed [DIFF_W-1:0] s1_rx, s1_ry, s1_rz;

  always_ff @(posedge clk) begin
    if (ready[1]) begin
      s1_rx <= DIFF_W'(center_x) - DIFF_W'(camera_x);
      s1_ry <= DIFF_W'(center_y) - DIFF_W'(camera_y);
      s1_rz <= DIFF_W'(center_z) - DIFF_W'(camera_z);
    end
  end

  // stage 2: component products and squares
  logic signed [PROD_W-1:0]   s2_px, s2_py, s2_pz;
  logic [RSQ_W-1:0]           s2_rsx, s2_rsy, s2_rsz;
  logic [NSQ_W-1:0]           s2_nsx, s2_nsy, s2_nsz;
  logic                       s2_r_zero;
  logic signed [PROD_W-1:0]   px, py, pz;
  logic signed [2*DIFF_W-1:0] rsx, rsy, rsz;
  logic signed [2*COORD_WIDTH-1:0] nsx, nsy, nsz;

  always_comb begin
    px  = PROD_W'(s1_rx) * PROD_W'(normal_x);
    py  = PROD_W'(s1_ry) * PROD_W'(normal_y);
    pz  = PROD_W'(s1_rz) * PROD_W'(normal_z);
    rsx = (2*DIFF_W)'(s1_rx) * (2*DIFF_W)'(s1_rx);
    rsy = (2*DIFF_W)'(s1_ry) * (2*DIFF_W)'(s1_ry);
    rsz = (2*DIFF_W)'(s1_rz) * (2*DIFF_W)'(s1_rz);
    nsx = (2*COORD_WIDTH)'(normal_x) * (2*COORD_WIDTH)'(normal_x);
    nsy = (2*COORD_WIDTH)'(normal_y) * (2*COORD_WIDTH)'(normal_y);
    nsz = (2*COORD_WIDTH)'(normal_z) * (2*COORD_WIDTH)'(normal_z);
  end

  always_ff @(posedge clk) begin
    if (ready[2]) begin
      s2_px     <= px;
      s2_py     <= py;
      s2_pz     <= pz;
      s2_rsx    <= rsx[RSQ_W-1:0];
      s2_rsy    <= rsy[RSQ_W-1:0];
      s2_rsz    <= rsz[RSQ_W-1:0];
      s2_nsx    <= nsx[NSQ_W-1:0];
      s2_nsy    <= nsy[NSQ_W-1:0];
      s2_nsz    <= nsz[NSQ_W-1:0];
      s2_r_zero <= (s1_rx == '0) && (s1_ry == '0) && (s1_rz == '0);
    end
  end

  // stage 3: dot product, squared lengths, squared cosine and reach
  logic signed [DOT_W-1:0]   s3_dot;
  logic [R2_W-1:0]           s3_r2;
  logic [N2_W-1:0]           s3_n2;
  logic [C2_W-1:0]           s3_c2;
  logic [RE2_W-1:0]          s3_re2;
  logic                      s3_r_zero;
  logic signed [2*FIX_W-1:0] c2_full;

  assign c2_full = (2*FIX_W)'(cos_half_angle) * (2*FIX_W)'(cos_half_angle);

  always_ff @(posedge clk) begin
    if (ready[3]) begin
      s3_dot    <= DOT_W'(s2_px) + DOT_W'(s2_py) + DOT_W'(s2_pz);
      s3_r2     <= R2_W'(s2_rsx) + R2_W'(s2_rsy) + R2_W'(s2_rsz);
      s3_n2     <= N2_W'(s2_nsx) + N2_W'(s2_nsy) + N2_W'(s2_nsz);
      s3_c2     <= c2_full[C2_W-1:0];
      s3_re2    <= RE2_W'(reach) * RE2_W'(reach);
      s3_r_zero <= s2_r_zero;
    end
  end

  // stage 4: magnitude of dot, |r|^2 |n|^2 and reach^2 |n|^2
  logic [DMAG_W-1:0]       s4_dmag;
  logic                    s4_dot_neg;
  logic [RN_W-1:0]         s4_rn;
  logic [DRE_W-1:0]        s4_dre;
  logic [C2_W-1:0]         s4_c2;
  logic                    s4_r_zero;
  logic signed [DOT_W-1:0] dot_abs;

  assign dot_abs = s3_dot[DOT_W-1] ? -s3_dot : s3_dot;

  always_ff @(posedge clk) begin
    if (ready[4]) begin
      s4_dmag    <= dot_abs[DMAG_W-1:0];
      s4_dot_neg <= s3_dot[DOT_W-1];
      s4_rn      <= RN_W'(s3_r2) * RN_W'(s3_n2);
      s4_dre     <= DRE_W'(s3_re2) * DRE_W'(s3_n2);
      s4_c2      <= s3_c2;
      s4_r_zero  <= s3_r_zero;
    end
  end

  // stage 5: dot squared and the two halves of cos^2 |r|^2 |n|^2
  logic [DOT2_W-1:0]  s5_dot2;
  logic [PP_LO_W-1:0] s5_pp_lo;
  logic [PP_HI_W-1:0] s5_pp_hi;
  logic [DRE_W-1:0]   s5_dre;
  logic               s5_dot_neg;
  logic               s5_r_zero;

  always_ff @(posedge clk) begin
    if (ready[5]) begin
      s5_dot2    <= DOT2_W'(s4_dmag) * DOT2_W'(s4_dmag);
      s5_pp_lo   <= PP_LO_W'(s4_c2) * PP_LO_W'(s4_rn[RN_LO_W-1:0]);
      s5_pp_hi   <= PP_HI_W'(s4_c2) * PP_HI_W'(s4_rn[RN_W-1:RN_LO_W]);
      s5_dre     <= s4_dre;
      s5_dot_neg <= s4_dot_neg;
      s5_r_zero  <= s4_r_zero;
    end
  end

  // stage 6: join partial products, distance compare
  logic [CMP_W-1:0] s6_lhs;
  logic [CMP_W-1:0] s6_rhs;
  logic             s6_dist;
  logic             s6_dot_neg;
  logic             s6_r_zero;

  always_ff @(posedge clk) begin
    if (ready[6]) begin
      s6_lhs     <= CMP_W'(s5_dot2) << FRAC_SH;
      s6_rhs     <= CMP_W'(s5_pp_lo) + (CMP_W'(s5_pp_hi) << RN_LO_W);
      s6_dist    <= DIST_W'(s5_dot2) < DIST_W'(s5_dre);
      s6_dot_neg <= s5_dot_neg;
      s6_r_zero  <= s5_r_zero;
    end
  end

  // stage 7: cone compare and result register
  logic cone;

  always_comb begin
    if (s6_r_zero) begin
      cone = 1'b0;
    end else if (!s6_dot_neg) begin
      cone = (cos_half_angle <= 0) || (s6_lhs >= s6_rhs);
    end else begin
      // negative dot only passes a cone wider than a half space
      cone = (cos_half_angle < 0) && (s6_lhs <= s6_rhs);
    end
  end

  always_ff @(posedge clk) begin
    if (ready[7]) begin
      outside     <= n_zero || !(cone && s6_dist);
      zero_normal <= n_zero;
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for view_cone_and_plane_distance_test_core
// predicts the outside and zero_normal flags with exact wide-integer arithmetic
// depends on vcpd_pkg and the core RTL only
module tb;
  import vcpd_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef struct packed { coord_t x; coord_t y; coord_t z; } centre_t;
  typedef struct packed { logic outside; logic zero_normal; } cull_verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t center_x = '0;
  coord_t center_y = '0;
  coord_t center_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic outside;
  logic zero_normal;

  // settings as the core should now hold them
  coord_t cam [3];
  coord_t nrm [3];
  logic signed [FIX_W-1:0] cos_half;
  logic [FIX_W-1:0] reach;

  centre_t centres_queued [$];
  cull_verdict_t verdicts_due [$];
  centre_t head_centre;
  cull_verdict_t want;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int phase;

  view_cone_and_plane_distance_test_core u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .center_x   (center_x),
    .center_y   (center_y),
    .center_z   (center_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .outside    (outside),
    .zero_normal(zero_normal)
  );

  always #5 clk = ~clk;

  // exact test: all magnitude comparisons on squared values, no rounding
  function automatic cull_verdict_t cull_verdict(centre_t c);
    longint rv [3];
    longint nv [3];
    longint dot;
    longint r2;
    longint n2;
    longint cosv;
    logic [127:0] dot2;
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [127:0] dist_lim;
    logic cone;
    logic near;
    cull_verdict_t v;
    rv[0] = longint'($signed(c.x)) - longint'($signed(cam[0]));
    rv[1] = longint'($signed(c.y)) - longint'($signed(cam[1]));
    rv[2] = longint'($signed(c.z)) - longint'($signed(cam[2]));
    nv[0] = longint'($signed(nrm[0]));
    nv[1] = longint'($signed(nrm[1]));
    nv[2] = longint'($signed(nrm[2]));
    dot = rv[0] * nv[0] + rv[1] * nv[1] + rv[2] * nv[2];
    r2 = rv[0] * rv[0] + rv[1] * rv[1] + rv[2] * rv[2];
    n2 = nv[0] * nv[0] + nv[1] * nv[1] + nv[2] * nv[2];
    cosv = longint'($signed(cos_half));
    v.zero_normal = (n2 == 0);
    if (n2 == 0) begin
      v.outside = 1'b1;
      return v;
    end
    dot2 = 128'((dot < 0) ? -dot : dot);
    dot2 = dot2 * dot2;
    lhs = dot2 << 30;
    rhs = 128'(cosv * cosv) * 128'(r2) * 128'(n2);
    dist_lim = 128'(reach) * 128'(reach) * 128'(n2);
    // a centre on the camera has no direction, so it never lies in the cone
    if (r2 == 0) begin
      cone = 1'b0;
    end else if (dot >= 0) begin
      cone = (cosv <= 0) || (lhs >= rhs);
    end else begin
      cone = (cosv < 0) && (lhs <= rhs);
    end
    near = dot2 < dist_lim;
    v.outside = !(cone && near);
    return v;
  endfunction

  // driver: predicts each item as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        verdicts_due.push_back(cull_verdict({center_x, center_y, center_z}));
      if (!in_valid || !in_stall) begin
        if (centres_queued.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          head_centre = centres_queued.pop_front();
          in_valid <= 1'b1;
          center_x <= head_centre.x;
          center_y <= head_centre.y;
          center_z <= head_centre.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          $error("result with no item pending: outside=%0b zero_normal=%0b",
                 outside, zero_normal);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (outside !== want.outside) begin
            $error("outside: expected %0b, got %0b", want.outside, outside);
            mismatches++;
          end
          if (zero_normal !== want.zero_normal) begin
            $error("zero_normal: expected %0b, got %0b", want.zero_normal, zero_normal);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CAMERA_X: cam[0] = val;
      REG_CAMERA_Y: cam[1] = val;
      REG_CAMERA_Z: cam[2] = val;
      REG_NORMAL_X: nrm[0] = val;
      REG_NORMAL_Y: nrm[1] = val;
      REG_NORMAL_Z: nrm[2] = val;
      REG_COS_HALF: cos_half = val;
      REG_REACH:    reach = val;
      default: ;
    endcase
  endtask

  // wait for the pipeline to empty, then let it go quiet
  task automatic settle();
    do @(negedge clk);
    while (centres_queued.size() != 0 || in_valid || verdicts_due.size() != 0);
    repeat (NSTAGE + 3) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      1: begin send_gap_pct = 64; recv_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  recv_stall_pct = 64; end
      3: begin send_gap_pct = 24; recv_stall_pct = 24; end
      default: begin send_gap_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  task automatic queue_centre(input int x, input int y, input int z);
    centres_queued.push_back({coord_t'(x), coord_t'(y), coord_t'(z)});
  endtask

  task automatic randomise_config();
    logic [CFG_W-1:0] cv [3];
    logic [CFG_W-1:0] nv [3];
    logic [CFG_W-1:0] val;
    int k;
    int pick;
    int nmode;
    int axis;
    nmode = $urandom_range(6);
    axis = $urandom_range(2);
    for (k = 0; k < 3; k++) begin
      pick = $urandom_range(9);
      if (pick < 5) cv[k] = CFG_W'($urandom_range(4000) - 2000);
      else if (pick < 8) cv[k] = CFG_W'($urandom);
      else cv[k] = (pick == 8) ? 16'h8000 : 16'h7FFF;
      case (nmode)
        0, 1, 2: nv[k] = CFG_W'($urandom_range(128) - 64);
        3, 4:    nv[k] = CFG_W'($urandom);
        5:       nv[k] = (k == axis) ? CFG_W'($urandom) : '0;
        default: nv[k] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      endcase
    end
    write_reg(REG_CAMERA_X, cv[0]);
    write_reg(REG_CAMERA_Y, cv[1]);
    write_reg(REG_CAMERA_Z, cv[2]);
    write_reg(REG_NORMAL_X, nv[0]);
    write_reg(REG_NORMAL_Y, nv[1]);
    write_reg(REG_NORMAL_Z, nv[2]);
    pick = $urandom_range(9);
    case (pick)
      3, 4, 5: val = CFG_W'($urandom_range(32767, 16384));
      6:       val = 16'h8000;
      7:       val = 16'h7FFF;
      8:       val = '0;
      default: val = CFG_W'($urandom);
    endcase
    write_reg(REG_COS_HALF, val);
    pick = $urandom_range(9);
    case (pick)
      5, 6, 7: val = CFG_W'($urandom_range(65535, 1000));
      8:       val = '0;
      9:       val = 16'hFFFF;
      default: val = CFG_W'($urandom);
    endcase
    write_reg(REG_REACH, val);
  endtask

  // many centres along the view direction so both tests see pass and fail
  task automatic queue_random_centres(input int count);
    int p [3];
    int kind;
    int k;
    int s;
    int sh;
    int noise;
    repeat (count) begin
      kind = $urandom_range(9);
      for (k = 0; k < 3; k++) begin
        if (kind <= 3) begin
          p[k] = $urandom;
        end else if (kind <= 7) begin
          if (k == 0) begin
            s = $urandom_range(1023);
            sh = $urandom_range(15);
            if ($urandom_range(3) == 0) s = -s;
          end
          noise = $urandom_range(64);
          p[k] = int'(cam[k]) + ((int'(nrm[k]) * s) >>> sh) + noise - 32;
        end else if (kind == 8) begin
          case ($urandom_range(4))
            0: p[k] = -32768;
            1: p[k] = -1;
            2: p[k] = 0;
            3: p[k] = 1;
            default: p[k] = 32767;
          endcase
        end else begin
          p[k] = int'(cam[k]);
        end
      end
      // centre on the camera or a step away from it
      if (kind == 9) begin
        k = $urandom_range(3);
        if (k < 3) p[k] = p[k] + ($urandom_range(1) ? 1 : -1);
      end
      queue_centre(p[0], p[1], p[2]);
    end
  endtask

  initial begin
    cam[0] = '0;
    cam[1] = '0;
    cam[2] = '0;
    nrm[0] = '0;
    nrm[1] = '0;
    nrm[2] = coord_t'(1);
    cos_half = '0;
    reach = '0;
    set_idling(0);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero reach leaves everything outside
    queue_centre(0, 0, 0);
    queue_centre(0, 0, 5);
    queue_centre(32767, 32767, 32767);
    queue_centre(-32768, -32768, -32768);
    settle();

    // 45 degree half angle, widest reach
    write_reg(REG_REACH, 16'hFFFF);
    write_reg(REG_COS_HALF, 16'd23170);
    queue_centre(0, 0, 100);
    queue_centre(0, 0, -100);
    queue_centre(100, 0, 100);
    queue_centre(101, 0, 100);
    queue_centre(0, 0, 0);
    queue_centre(0, 0, 32767);
    queue_centre(0, 0, -32768);
    queue_centre(-32768, 32767, 0);
    settle();

    // full sphere cone, reach edge
    write_reg(REG_REACH, 16'd100);
    write_reg(REG_COS_HALF, 16'h8000);
    queue_centre(0, 0, 99);
    queue_centre(0, 0, 100);
    queue_centre(5, -7, -99);
    settle();

    write_reg(REG_NORMAL_Z, '0);
    queue_centre(1, 2, 3);
    queue_centre(0, 0, 0);
    settle();

    // opposite corners, narrowest cone
    write_reg(REG_CAMERA_X, 16'h7FFF);
    write_reg(REG_CAMERA_Y, 16'h7FFF);
    write_reg(REG_CAMERA_Z, 16'h7FFF);
    write_reg(REG_NORMAL_X, 16'h8000);
    write_reg(REG_NORMAL_Y, 16'h8000);
    write_reg(REG_NORMAL_Z, 16'h8000);
    write_reg(REG_COS_HALF, 16'h7FFF);
    write_reg(REG_REACH, 16'hFFFF);
    queue_centre(0, 0, 0);
    queue_centre(-32768, -32768, -32768);

    for (phase = 0; phase < 10; phase++) begin
      settle();
      randomise_config();
      set_idling(phase % 4);
      queue_random_centres(190);
    end

    settle();
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
